// ----- rtl/ctt_pkg.sv -----
package ctt_pkg;

   localparam int TIMER_SLOTS  = 64;
   localparam int SLOT_W       = $clog2(TIMER_SLOTS);
   localparam int CNT_W        = $clog2(TIMER_SLOTS + 1);
   localparam int RESULT_LIMIT = 64;
   localparam int PICK_W       = $clog2(RESULT_LIMIT + 1);
   localparam int DL_W         = 48;
   localparam logic [DL_W-1:0] DL_MAX = {DL_W{1'b1}};
   localparam logic signed [31:0] NO_TIMEOUT = -32'sd1;

   typedef enum logic [1:0] {
      FN_ADD    = 2'd0,
      FN_UPDATE = 2'd1,
      FN_REMOVE = 2'd2,
      FN_TICK   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STS_DONE      = 2'd0,
      STS_REPLACED  = 2'd1,
      STS_NOT_ARMED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT
   } fsm_type;

   typedef struct packed {
      logic              start;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [DL_W-1:0]   wr_data;
   } scan_ctl_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [DL_W-1:0]   best;
      logic [SLOT_W-1:0] idx;
   } scan_res_type;

endpackage

// ----- rtl/connection_timeout_table.sv -----
// connection timeout table: one millisecond deadline per connection slot
// request channel (req_valid/req_ready): req_func selects add, update,
// remove or tick; req_conn_id names the slot, req_timeout_ms the delay for
// add and update, req_elapsed_ms the clock advance for a tick
// response channel (rsp_valid/rsp_ready): one transfer per add, update or
// remove; a tick gives one transfer per expired slot in deadline order
// (ties by lower slot), or one empty transfer; rsp_last marks the final one
// every response carries the time to the earliest deadline and armed count
// storage: deadlines sit in a one-port-read memory swept once per response,
// and once more before the first response of a tick with expired slots
// one item is in flight at a time; req_ready is high only when idle
// reset clears the clock, the armed bits and the count; no clearing pass
// a stalled response holds in the output register; the sweep for the
// next expired slot runs meanwhile and its response waits for that
// register to be taken
module connection_timeout_table (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [5:0]         req_conn_id,
   input  logic [30:0]        req_timeout_ms,
   input  logic [15:0]        req_elapsed_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_expired_valid,
   output logic [5:0]         rsp_expired_slot,
   output logic signed [31:0] rsp_next_timeout,
   output logic [6:0]         rsp_armed_count,
   output logic               rsp_last
);

   localparam int SLOTS = ctt_pkg::TIMER_SLOTS;
   localparam int SW    = ctt_pkg::SLOT_W;
   localparam int DW    = ctt_pkg::DL_W;

   ctt_pkg::fsm_type state_ff, state_in;

   // latched request
   ctt_pkg::func_type    func_ff;
   logic [5:0]           id_ff;
   logic [30:0]          tmo_ff;
   logic [15:0]          el_ff;

   // table state outside the memory
   logic [DW-1:0]                now_ff, now_in;
   logic [SLOTS-1:0]             armed_ff, armed_in;
   logic [ctt_pkg::CNT_W-1:0]    total_ff, total_in;
   ctt_pkg::status_type          status_ff, status_in;
   logic [ctt_pkg::PICK_W-1:0]   picks_ff, picks_in;
   logic [SW-1:0]                pend_ff, pend_in;
   logic                         pend_vld_ff, pend_vld_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic                 rsp_exp_vld_ff, rsp_exp_vld_in;
   logic [5:0]           rsp_slot_ff, rsp_slot_in;
   logic signed [31:0]   rsp_nt_ff, rsp_nt_in;
   logic [6:0]           rsp_cnt_ff, rsp_cnt_in;
   logic                 rsp_last_ff, rsp_last_in;

   ctt_pkg::scan_ctl_type scan_ctl;
   ctt_pkg::scan_res_type scan_res;

   // control strobes
   logic          req_xfer;
   logic          is_tick;
   logic          slot_ok;
   logic [SW-1:0] id_idx;
   logic          id_armed;
   logic          due;
   logic          more;
   logic          decide_pick;
   logic          emit_fire;
   logic          emit_more;
   logic          pick;
   logic [DW:0]   now_sum;
   logic [DW:0]   dl_sum;
   logic [DW-1:0] dl_new;

   assign req_xfer = req_valid && req_ready;
   assign is_tick  = (func_ff == ctt_pkg::FN_TICK);
   assign slot_ok  = (32'(id_ff) < SLOTS);
   assign id_idx   = SW'(id_ff);
   assign id_armed = slot_ok && armed_ff[id_idx];

   // earliest armed deadline already reached, and room left in this tick
   assign due  = scan_res.found && (scan_res.best <= now_ff);
   assign more = due && (picks_ff < ctt_pkg::PICK_W'(ctt_pkg::RESULT_LIMIT));

   assign now_sum = {1'b0, now_ff} + (DW + 1)'(el_ff);
   assign dl_sum  = {1'b0, now_ff} + (DW + 1)'(tmo_ff);
   assign dl_new  = dl_sum[DW] ? ctt_pkg::DL_MAX : dl_sum[DW-1:0];

   ctt_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .armed (armed_ff),
      .res   (scan_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ctt_pkg::ST_EXEC;
            end
         end
         ctt_pkg::ST_EXEC: begin
            state_in = ctt_pkg::ST_SCAN;
         end
         ctt_pkg::ST_SCAN: begin
            if (scan_res.done) begin
               state_in = ctt_pkg::ST_DECIDE;
            end
         end
         ctt_pkg::ST_DECIDE: begin
            state_in = decide_pick ? ctt_pkg::ST_SCAN : ctt_pkg::ST_EMIT;
         end
         ctt_pkg::ST_EMIT: begin
            if (emit_fire) begin
               state_in = emit_more ? ctt_pkg::ST_SCAN : ctt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctt_pkg::ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready        = 1'b0;
      decide_pick      = 1'b0;
      emit_fire        = 1'b0;
      emit_more        = 1'b0;
      scan_ctl.start   = 1'b0;
      scan_ctl.wr_en   = 1'b0;
      scan_ctl.wr_addr = id_idx;
      scan_ctl.wr_data = dl_new;
      case (state_ff)
         ctt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         ctt_pkg::ST_EXEC: begin
            scan_ctl.start = 1'b1;
            // add always writes; update only rewrites an armed slot
            scan_ctl.wr_en = !is_tick && slot_ok &&
                             ((func_ff == ctt_pkg::FN_ADD) ||
                              ((func_ff == ctt_pkg::FN_UPDATE) && id_armed));
         end
         ctt_pkg::ST_SCAN: begin
         end
         ctt_pkg::ST_DECIDE: begin
            // first expiry of a tick: disarm it and sweep again for the
            // next timeout that its response reports
            decide_pick    = is_tick && !pend_vld_ff && more;
            scan_ctl.start = decide_pick;
         end
         ctt_pkg::ST_EMIT: begin
            emit_fire      = !rsp_valid_ff || rsp_ready;
            emit_more      = emit_fire && is_tick && more;
            scan_ctl.start = emit_more;
         end
         default: begin
         end
      endcase
   end

   assign pick = decide_pick || emit_more;

   // table and response datapath
   always_comb begin
      now_in      = now_ff;
      armed_in    = armed_ff;
      total_in    = total_ff;
      status_in   = status_ff;
      picks_in    = picks_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;

      if (state_ff == ctt_pkg::ST_EXEC) begin
         picks_in    = '0;
         pend_vld_in = 1'b0;
         status_in   = ctt_pkg::STS_DONE;
         if (is_tick) begin
            now_in = now_sum[DW] ? ctt_pkg::DL_MAX : now_sum[DW-1:0];
         end else if (!slot_ok) begin
            status_in = ctt_pkg::STS_NOT_ARMED;
         end else begin
            case (func_ff)
               ctt_pkg::FN_ADD: begin
                  if (id_armed) begin
                     status_in = ctt_pkg::STS_REPLACED;
                  end else begin
                     armed_in[id_idx] = 1'b1;
                     total_in         = total_ff + 1'b1;
                  end
               end
               ctt_pkg::FN_UPDATE: begin
                  if (!id_armed) begin
                     status_in = ctt_pkg::STS_NOT_ARMED;
                  end
               end
               ctt_pkg::FN_REMOVE: begin
                  if (id_armed) begin
                     armed_in[id_idx] = 1'b0;
                     total_in         = total_ff - 1'b1;
                  end else begin
                     status_in = ctt_pkg::STS_NOT_ARMED;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      // expired slot leaves the table before the sweep that follows
      if (pick) begin
         armed_in[scan_res.idx] = 1'b0;
         total_in               = total_ff - 1'b1;
         picks_in               = picks_ff + 1'b1;
         pend_in                = scan_res.idx;
         pend_vld_in            = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_exp_vld_in = rsp_exp_vld_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_nt_in      = rsp_nt_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = is_tick ? ctt_pkg::STS_DONE : status_ff;
         rsp_exp_vld_in = pend_vld_ff;
         rsp_slot_in    = pend_vld_ff ? 6'(pend_ff) : 6'd0;
         if (!scan_res.found) begin
            rsp_nt_in = ctt_pkg::NO_TIMEOUT;
         end else if (due) begin
            rsp_nt_in = '0;
         end else begin
            rsp_nt_in = 32'(scan_res.best - now_ff);
         end
         rsp_cnt_in  = 7'(total_ff);
         rsp_last_in = !(is_tick && more);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctt_pkg::ST_IDLE;
         now_ff       <= '0;
         armed_ff     <= '0;
         total_ff     <= '0;
         picks_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         armed_ff     <= armed_in;
         total_ff     <= total_in;
         picks_ff     <= picks_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff      <= status_in;
      pend_ff        <= pend_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_exp_vld_ff <= rsp_exp_vld_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_nt_ff      <= rsp_nt_in;
      rsp_cnt_ff     <= rsp_cnt_in;
      rsp_last_ff    <= rsp_last_in;
      if (req_xfer) begin
         func_ff <= ctt_pkg::func_type'(req_func);
         id_ff   <= req_conn_id;
         tmo_ff  <= req_timeout_ms;
         el_ff   <= req_elapsed_ms;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_expired_valid = rsp_exp_vld_ff;
   assign rsp_expired_slot  = rsp_slot_ff;
   assign rsp_next_timeout  = rsp_nt_ff;
   assign rsp_armed_count   = rsp_cnt_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ----- rtl/ctt_scan.sv -----
module ctt_scan (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ctt_pkg::scan_ctl_type                   ctl,
   input  logic [ctt_pkg::TIMER_SLOTS-1:0]         armed,
   output ctt_pkg::scan_res_type                   res
);

   // deadline store, one synchronous read port used by the sweep
   logic [ctt_pkg::DL_W-1:0]   mem [ctt_pkg::TIMER_SLOTS];
   logic [ctt_pkg::DL_W-1:0]   mem_q_ff;

   logic [ctt_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                       run_ff, run_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [ctt_pkg::SLOT_W-1:0] rd_idx_ff, rd_idx_in;
   logic                       rd_armed_ff, rd_armed_in;
   logic                       found_ff, found_in;
   logic [ctt_pkg::DL_W-1:0]   best_ff, best_in;
   logic [ctt_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic                       done_ff, done_in;
   logic                       issue;
   logic [ctt_pkg::SLOT_W-1:0] rd_addr;

   assign rd_addr = cnt_ff[ctt_pkg::SLOT_W-1:0];
   assign issue   = run_ff && (cnt_ff < ctt_pkg::CNT_W'(ctt_pkg::TIMER_SLOTS));

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (issue) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      cnt_in      = cnt_ff;
      run_in      = run_ff;
      rd_vld_in   = issue;
      rd_idx_in   = rd_addr;
      rd_armed_in = armed[rd_addr];
      found_in    = found_ff;
      best_in     = best_ff;
      idx_in      = idx_ff;
      done_in     = 1'b0;
      if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
      // strict less-than keeps the lowest slot on equal deadlines
      if (rd_vld_ff && rd_armed_ff && (!found_ff || mem_q_ff < best_ff)) begin
         found_in = 1'b1;
         best_in  = mem_q_ff;
         idx_in   = rd_idx_ff;
      end
      if (run_ff && !issue && !rd_vld_ff) begin
         run_in  = 1'b0;
         done_in = 1'b1;
      end
      if (ctl.start) begin
         cnt_in   = '0;
         run_in   = 1'b1;
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         run_ff    <= 1'b0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         run_ff    <= run_in;
         rd_vld_ff <= rd_vld_in;
         found_ff  <= found_in;
         done_ff   <= done_in;
      end
      rd_idx_ff   <= rd_idx_in;
      rd_armed_ff <= rd_armed_in;
      best_ff     <= best_in;
      idx_ff      <= idx_in;
   end

   assign res.done  = done_ff;
   assign res.found = found_ff;
   assign res.best  = best_ff;
   assign res.idx   = idx_ff;

endmodule

// ----- rtl/ctt_checker.sv -----
module ctt_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_expired_valid,
   input  logic [5:0]         rsp_expired_slot,
   input  logic signed [31:0] rsp_next_timeout,
   input  logic [6:0]         rsp_armed_count,
   input  logic               rsp_last
);

   // no response right out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_expired_valid) && $stable(rsp_expired_slot) &&
      $stable(rsp_next_timeout) && $stable(rsp_armed_count) && $stable(rsp_last))
      else $error("stalled response changed");

   // one item in flight: busy right after a request transfer
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   // more responses follow a non-final one, so no request is taken meanwhile
   a_burst_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken inside a response burst");

   // only expiry responses come in bursts, and they report done
   a_burst_expiry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |->
      rsp_expired_valid && (rsp_status == ctt_pkg::STS_DONE))
      else $error("non-final response is not an expiry");

endmodule

bind connection_timeout_table ctt_checker u_ctt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_expired_valid (rsp_expired_valid),
   .rsp_expired_slot  (rsp_expired_slot),
   .rsp_next_timeout  (rsp_next_timeout),
   .rsp_armed_count   (rsp_armed_count),
   .rsp_last          (rsp_last)
);
